@@ hw/rtl/vrt_pkg.sv @@
// shared types and constants for the voxel ray traversal block
// no dependencies
package vrt_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIR_BITS   = 16;
  localparam int STEP_BITS  = 16;
  localparam int ORIGIN_W   = 48;
  localparam int HEAD_W     = 16;
  localparam int CELL_W     = 32;
  localparam int T_BITS     = 40;
  // root bits: integer digits plus fraction digits
  localparam int LEN_W      = DIR_BITS + 1 + FRAC_BITS;
  localparam int REM_W      = LEN_W + 3;
  localparam int SS_W       = 2 * DIR_BITS;
  localparam int CNT_W      = $clog2(LEN_W + 1);

  localparam logic [T_BITS-1:0] T_MAX = {T_BITS{1'b1}};

  localparam logic OP_START  = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [1:0]        axis;
    logic [T_BITS-1:0] crossing;
  } vrt_pick_t;

endpackage

@@ hw/rtl/vrt_step_unit.sv @@
// axis selection and saturating crossing update for one traversal step
// depends on vrt_pkg
module vrt_step_unit (
  input  logic [vrt_pkg::T_BITS-1:0] next_crossing [3],
  input  logic [vrt_pkg::T_BITS-1:0] crossing_step [3],
  input  logic [2:0]                 axis_is_zero,
  output vrt_pkg::vrt_pick_t         pick
);
  import vrt_pkg::*;

  logic [T_BITS-1:0] tx, ty, tz;
  logic              zx, zy, zz;
  logic [1:0]        ax;
  logic [T_BITS:0]   sum;

  // smallest crossing, ties x then y then z, zero axes skipped
  always_comb begin
    tx = next_crossing[0];
    ty = next_crossing[1];
    tz = next_crossing[2];
    zx = axis_is_zero[0];
    zy = axis_is_zero[1];
    zz = axis_is_zero[2];
    priority if (!zx && (zy || tx <= ty) && (zz || tx <= tz)) ax = AX_X;
    else if (!zy && (zx || ty <= tx) && (zz || ty <= tz)) ax = AX_Y;
    else ax = AX_Z;
  end

  // saturating add of the step distance
  always_comb begin
    sum = {1'b0, next_crossing[ax]} + {1'b0, crossing_step[ax]};
    pick.axis = ax;
    pick.crossing = sum[T_BITS] ? T_MAX : sum[T_BITS-1:0];
  end

endmodule

@@ hw/rtl/voxel_ray_traversal.sv @@
// voxel ray traversal top level: start setup through one shared compare-subtract
// unit (square root, then three divisions), then at most one cell step per answer item.
// start item: the root and divide steps produce one digit per cycle; degenerate rays
//   skip them and go straight to the result
// answer item: one item at a time, stall high while busy
// reset: synchronous, clears the sequencer and the active-ray flag; depends on vrt_pkg
module voxel_ray_traversal (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [vrt_pkg::ORIGIN_W-1:0]   origin_x,
  input  logic [vrt_pkg::ORIGIN_W-1:0]   origin_y,
  input  logic [vrt_pkg::ORIGIN_W-1:0]   origin_z,
  input  logic [vrt_pkg::HEAD_W-1:0]     heading_x,
  input  logic [vrt_pkg::HEAD_W-1:0]     heading_y,
  input  logic [vrt_pkg::HEAD_W-1:0]     heading_z,
  input  logic [15:0]                    max_steps,
  input  logic                           stop_before,
  input  logic                           cell_solid,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           result_kind,
  output logic [vrt_pkg::CELL_W-1:0]     cell_x,
  output logic [vrt_pkg::CELL_W-1:0]     cell_y,
  output logic [vrt_pkg::CELL_W-1:0]     cell_z
);
  import vrt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_SQRT = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_STEP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic [CNT_W-1:0]      cnt;
  logic [1:0]            axis;
  logic                  ray_active;
  logic [STEP_BITS-1:0]  steps_left;
  logic                  back_off_flag;
  logic [1:0]            last_axis;
  logic [COORD_BITS-1:0] current_cell [3];
  logic [T_BITS-1:0]     next_crossing [3];
  logic [T_BITS-1:0]     crossing_step [3];
  logic [2:0]            axis_sign_negative;
  logic [2:0]            axis_is_zero;
  logic [FRAC_BITS-1:0]  frac [3];
  logic [DIR_BITS-1:0]   mag [3];
  logic [SS_W-1:0]       acc;
  logic [2*LEN_W-1:0]    radicand;
  logic [LEN_W-1:0]      root;
  logic [REM_W-1:0]      rem;
  logic [LEN_W-1:0]      dq;
  logic                  out_kind;
  logic [COORD_BITS-1:0] out_cell [3];

  logic                  in_accept;
  logic [ORIGIN_W-1:0]   org [3];
  logic [DIR_BITS-1:0]   head [3];
  logic [COORD_BITS-1:0] floor_cell [3];
  logic [2:0]            head_zero;
  logic [2:0]            head_neg;
  logic [DIR_BITS-1:0]   head_mag [3];
  logic [SS_W-1:0]       acc_next;
  logic [REM_W-1:0]      sub_a, sub_b;
  logic [REM_W:0]        diff;
  logic                  ge;
  logic [LEN_W-1:0]      quo;
  logic [LEN_W+T_BITS-1:0] quo_wide;
  logic [T_BITS-1:0]     quo_sat;
  logic [FRAC_BITS:0]    face_dist;
  logic [T_BITS+FRAC_BITS:0] prod;
  logic [T_BITS-1:0]     t_sat;
  vrt_pick_t             pick;
  logic [COORD_BITS-1:0] step_cell [3];
  logic [COORD_BITS-1:0] back_cell [3];

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_accept = in_valid && !in_stall;

  assign result_kind = out_kind;
  assign cell_x = CELL_W'(signed'(out_cell[0]));
  assign cell_y = CELL_W'(signed'(out_cell[1]));
  assign cell_z = CELL_W'(signed'(out_cell[2]));

  // start item decode: floor, sign and magnitude per axis
  always_comb begin
    org[0] = origin_x;
    org[1] = origin_y;
    org[2] = origin_z;
    head[0] = heading_x[DIR_BITS-1:0];
    head[1] = heading_y[DIR_BITS-1:0];
    head[2] = heading_z[DIR_BITS-1:0];
    for (int a = 0; a < 3; a++) begin
      floor_cell[a] = COORD_BITS'(signed'(org[a]) >>> FRAC_BITS);
      head_zero[a]  = (head[a] == '0);
      head_neg[a]   = head[a][DIR_BITS-1] || head_zero[a];
      head_mag[a]   = head[a][DIR_BITS-1] ? (~head[a] + 1'b1) : head[a];
    end
  end

  // sum of squares accumulation, one axis per cycle
  assign acc_next = acc + SS_W'(mag[axis]) * SS_W'(mag[axis]);

  // shared compare-subtract unit: root digits and quotient bits
  always_comb begin
    if (state == S_SQRT) begin
      sub_a = {rem[REM_W-3:0], radicand[2*LEN_W-1 -: 2]};
      sub_b = REM_W'({root, 2'b01});
    end else begin
      sub_a = {rem[REM_W-2:0], dq[LEN_W-1]};
      sub_b = REM_W'(mag[axis]);
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[REM_W];
  end

  // quotient with saturation to the crossing width
  always_comb begin
    quo      = {dq[LEN_W-2:0], ge};
    quo_wide = (LEN_W+T_BITS)'(quo);
    quo_sat  = (|(quo_wide >> T_BITS)) ? T_MAX : quo_wide[T_BITS-1:0];
  end

  // first crossing: step times distance to the next face
  always_comb begin
    face_dist = axis_sign_negative[axis] ? {1'b0, frac[axis]}
                                         : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, frac[axis]};
    prod  = crossing_step[axis] * face_dist;
    t_sat = (|(prod >> (FRAC_BITS + T_BITS))) ? T_MAX : prod[FRAC_BITS +: T_BITS];
  end

  vrt_step_unit u_step (
    .next_crossing (next_crossing),
    .crossing_step (crossing_step),
    .axis_is_zero  (axis_is_zero),
    .pick          (pick)
  );

  // stepped cell and backed-off cell
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      step_cell[a] = current_cell[a];
      back_cell[a] = current_cell[a];
    end
    step_cell[pick.axis] = axis_sign_negative[pick.axis] ? current_cell[pick.axis] - 1'b1
                                                         : current_cell[pick.axis] + 1'b1;
    if (back_off_flag) begin
      back_cell[last_axis] = axis_sign_negative[last_axis] ? current_cell[last_axis] + 1'b1
                                                           : current_cell[last_axis] - 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ray_active <= 1'b0;
      cnt        <= '0;
      axis       <= AX_X;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept && op == OP_START) begin
            for (int a = 0; a < 3; a++) begin
              current_cell[a] <= floor_cell[a];
              frac[a]         <= org[a][FRAC_BITS-1:0];
              mag[a]          <= head_mag[a];
              out_cell[a]     <= floor_cell[a];
            end
            axis_is_zero       <= head_zero;
            axis_sign_negative <= head_neg;
            back_off_flag      <= stop_before;
            steps_left         <= max_steps[STEP_BITS-1:0];
            last_axis          <= AX_X;
            acc                <= '0;
            axis               <= AX_X;
            if (&head_zero || max_steps[STEP_BITS-1:0] == '0) begin
              ray_active <= 1'b0;
              out_kind   <= KIND_FINAL;
              state      <= S_OUT;
            end else begin
              state <= S_SQ;
            end
          end else if (in_accept && ray_active) begin
            if (cell_solid) begin
              ray_active <= 1'b0;
              out_kind   <= KIND_FINAL;
              out_cell   <= back_cell;
              state      <= S_OUT;
            end else if (steps_left == '0) begin
              ray_active <= 1'b0;
              out_kind   <= KIND_FINAL;
              out_cell   <= current_cell;
              state      <= S_OUT;
            end else begin
              state <= S_STEP;
            end
          end
        end
        S_SQ: begin
          acc <= acc_next;
          if (axis == AX_Z) begin
            radicand <= (2*LEN_W)'(acc_next) << (2 * FRAC_BITS);
            root     <= '0;
            rem      <= '0;
            cnt      <= '0;
            state    <= S_SQRT;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        S_SQRT: begin
          radicand <= radicand << 2;
          root     <= {root[LEN_W-2:0], ge};
          rem      <= ge ? diff[REM_W-1:0] : sub_a;
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(LEN_W - 1)) begin
            dq    <= {root[LEN_W-2:0], ge};
            rem   <= '0;
            cnt   <= '0;
            axis  <= AX_X;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dq  <= quo;
          rem <= ge ? diff[REM_W-1:0] : sub_a;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(LEN_W - 1)) begin
            crossing_step[axis] <= axis_is_zero[axis] ? '0 : quo_sat;
            dq  <= root;
            rem <= '0;
            cnt <= '0;
            if (axis == AX_Z) begin
              axis  <= AX_X;
              state <= S_MUL;
            end else begin
              axis <= axis + 1'b1;
            end
          end
        end
        S_MUL: begin
          next_crossing[axis] <= axis_is_zero[axis] ? '0 : t_sat;
          if (axis == AX_Z) begin
            state <= S_STEP;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        S_STEP: begin
          next_crossing[pick.axis] <= pick.crossing;
          current_cell             <= step_cell;
          out_cell                 <= step_cell;
          last_axis                <= pick.axis;
          steps_left               <= steps_left - 1'b1;
          ray_active               <= 1'b1;
          out_kind                 <= KIND_QUERY;
          state                    <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the block never takes an item while a result waits
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input ready while a result is pending");

  // an answer with no active ray yields nothing
  a_idle_answer_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op == OP_ANSWER && !ray_active) |=> !out_valid)
    else $error("result produced for an answer with no active ray");

  // digit counter stays within the root and divide length
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT || state == S_DIV) |-> cnt < CNT_W'(LEN_W))
    else $error("digit counter out of range");

  // a query result always comes with an active ray
  a_query_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_QUERY) |-> ray_active)
    else $error("query issued without an active ray");

endmodule
